/* hw/rtl/espd_pkg.sv */
// Shared types and constants for the encoder period speed estimator.
// Holds the item structs, the register and kind codes, and the
// controller-to-datapath command and status structs. No dependencies.
package espd_pkg;

	localparam logic [1:0] KIND_BLIP  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;

	localparam logic [1:0] REG_CIRCUMFERENCE = 2'd0;
	localparam logic [1:0] REG_BLIPS_PER_ROT = 2'd1;
	localparam logic [1:0] REG_WINDOW_SIZE   = 2'd2;

	localparam int QUO_W = 32;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [31:0] speed;
		logic        window_full;
	} out_item_t;

	typedef struct packed {
		logic upd;
		logic cnt;
		logic sum;
		logic mul;
		logic init;
		logic step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sum_done;
		logic early;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/espd_ctrl.sv */
// Controller state machine of the encoder period speed estimator.
// Sequences update, ring summing, multiply, serial divide and output load.
// Depends on espd_pkg for the command and status structs.
module espd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  espd_pkg::sts_t   sts,
	output espd_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_CNT  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_INIT = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_nxt = S_CNT;
			end
			S_CNT: begin
				cmd.cnt = 1'b1;
				state_nxt = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				if (sts.sum_done) begin
					state_nxt = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_nxt = S_INIT;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				if (sts.early) begin
					state_nxt = S_DONE;
				end else begin
					cmd.step = 1'b1;
					if (sts.div_last) begin
						state_nxt = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

/* hw/rtl/espd_dpath.sv */
// Datapath of the encoder period speed estimator: configuration registers,
// interval ring memory, sum accumulator, multipliers, serial divider and
// output register. Depends on espd_pkg; driven by espd_ctrl.
module espd_dpath #(
	parameter int WINDOW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  espd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output espd_pkg::out_item_t out_item,
	input  espd_pkg::cmd_t      cmd,
	output espd_pkg::sts_t      sts
);

	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);
	localparam int SW = 32 + CW;
	localparam int NW = 32 + CW;
	localparam int DW = 16 + SW;
	localparam int QW = espd_pkg::QUO_W;

	logic [31:0] circ_q;
	logic [15:0] bpr_q;
	logic [4:0]  win_size_q;

	logic [1:0]  kind_q;
	logic [31:0] now_q;

	logic [31:0] ring_mem [WINDOW];
	logic [IW-1:0] wr_idx_q;
	logic [31:0] last_blip_q;
	logic        full_q;

	logic [CW-1:0] w_eff;
	logic [CW-1:0] idx_eff;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] count_c;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [31:0]   rd_data_s1;
	logic          rd_vld_s1;
	logic [SW-1:0] sum_q;
	logic [15:0]   bpr_eff;

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [4:0]    step_q;
	logic          zero_q;
	logic          sat_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;

	logic          out_valid_q;
	espd_pkg::out_item_t out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q     <= 32'd0;
			bpr_q      <= 16'd1;
			win_size_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				espd_pkg::REG_CIRCUMFERENCE: circ_q <= cfg_data;
				espd_pkg::REG_BLIPS_PER_ROT: bpr_q <= cfg_data[15:0];
				espd_pkg::REG_WINDOW_SIZE:   win_size_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (win_size_q == 5'd0) begin
			w_eff = CW'(1);
		end else if (32'(win_size_q) > 32'(WINDOW)) begin
			w_eff = CW'(WINDOW);
		end else begin
			w_eff = CW'(win_size_q);
		end
	end

	assign idx_eff = (CW'(wr_idx_q) >= w_eff) ? '0 : CW'(wr_idx_q);
	assign idx_inc = idx_eff + CW'(1);
	assign count_c = full_q ? w_eff : ((CW'(wr_idx_q) < w_eff) ? CW'(wr_idx_q) : w_eff);
	assign bpr_eff = (bpr_q == 16'd0) ? 16'd1 : bpr_q;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_q <= in_item.kind;
			now_q  <= in_item.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			last_blip_q <= 32'd0;
			full_q      <= 1'b0;
		end else if (cmd.upd) begin
			if (kind_q == espd_pkg::KIND_BLIP) begin
				last_blip_q <= now_q;
				if (idx_inc >= w_eff) begin
					wr_idx_q <= '0;
					full_q   <= 1'b1;
				end else begin
					wr_idx_q <= idx_inc[IW-1:0];
				end
			end else if (kind_q == espd_pkg::KIND_CLEAR) begin
				wr_idx_q <= '0;
				full_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && kind_q == espd_pkg::KIND_BLIP) begin
			ring_mem[idx_eff[IW-1:0]] <= now_q - last_blip_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum && ptr_q < count_q) begin
			rd_data_s1 <= ring_mem[ptr_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.sum && (ptr_q < count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt) begin
			count_q <= count_c;
			ptr_q   <= '0;
			sum_q   <= '0;
		end else if (cmd.sum) begin
			if (ptr_q < count_q) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (rd_vld_s1) begin
				sum_q <= sum_q + {{CW{1'b0}}, rd_data_s1};
			end
		end
	end

	assign sts.sum_done = (ptr_q == count_q) && !rd_vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			num_q <= {{CW{1'b0}}, circ_q} * {{32{1'b0}}, count_q};
			den_q <= {{SW{1'b0}}, bpr_eff} * {16'd0, sum_q};
		end
	end

	assign trial = {rem_q, quo_q[QW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			rem_q  <= {{(DW-CW){1'b0}}, num_q[NW-1:QW]};
			quo_q  <= num_q[QW-1:0];
			step_q <= 5'd0;
			zero_q <= (num_q == '0);
			sat_q  <= (den_q <= {{(DW-CW){1'b0}}, num_q[NW-1:QW]});
		end else if (cmd.step) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q  <= {quo_q[QW-2:0], ge};
			step_q <= step_q + 5'd1;
		end
	end

	assign sts.early    = zero_q || sat_q;
	assign sts.div_last = (step_q == 5'd31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_item_q.window_full <= full_q;
			if (zero_q) begin
				out_item_q.speed <= 32'd0;
			end else if (sat_q) begin
				out_item_q.speed <= 32'hFFFF_FFFF;
			end else begin
				out_item_q.speed <= quo_q;
			end
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_item     = out_item_q;

endmodule

/* hw/rtl/encoder_period_speed_estimator.sv */
// An accepted item passes through the update, count, ring sum (one ring read per held
// interval, count being the number held, at most WINDOW), multiply, divider init, divide
// and output load states before out_valid rises. A zero or saturated result skips the
// 32-step serial divider. No new item is accepted until the result has been loaded into
// the output register, so a stalled result delays the next item.
// Reset clears the write index, last blip time and full flag and restores register defaults.
module encoder_period_speed_estimator #(
	parameter int WINDOW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  espd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output espd_pkg::out_item_t out_item
);

	espd_pkg::cmd_t cmd;
	espd_pkg::sts_t sts;

	espd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	espd_dpath #(
		.WINDOW (WINDOW)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
